FILE: design/motor_feedback_frame_parser_top_assert.svh
// Assertion macros shared by the motor feedback frame parser checkers.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef MOTOR_FEEDBACK_FRAME_PARSER_TOP_ASSERT_SVH
`define MOTOR_FEEDBACK_FRAME_PARSER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mffp_pkg.sv
package mffp_pkg;

  // Line framing
  localparam int unsigned MaxLineBytes = 255;
  localparam int unsigned CountW       = $clog2(MaxLineBytes + 1);

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  localparam logic [CountW-1:0] FrameLen = CountW'(17);

  // Byte positions within a line (0 based)
  localparam logic [CountW-1:0] PosHdrFirst  = CountW'(2);
  localparam logic [CountW-1:0] PosHdrLast   = CountW'(5);
  localparam logic [CountW-1:0] PosAngleHi   = CountW'(7);
  localparam logic [CountW-1:0] PosAngleLo   = CountW'(8);
  localparam logic [CountW-1:0] PosVelHi     = CountW'(9);
  localparam logic [CountW-1:0] PosVelLo     = CountW'(10);
  localparam logic [CountW-1:0] PosTorqueHi  = CountW'(11);
  localparam logic [CountW-1:0] PosTorqueLo  = CountW'(12);
  localparam logic [CountW-1:0] PosTempHi    = CountW'(13);
  localparam logic [CountW-1:0] PosTempLo    = CountW'(14);

  // Frame type expected in the shifted header
  localparam logic [7:0] FrameTypeFeedback = 8'd2;

  // Conversion constants
  localparam logic [35:0] AngleScale  = 36'd53972150818;  // 4*pi*2^32 rounded
  localparam logic [51:0] AngleBias   = 52'd65535 << 19;  // half of 65535*2^20
  localparam logic [14:0] VelScale    = 15'd30720;        // 30 * 2^10
  localparam logic [14:0] TorqueScale = 15'd24576;        // 12 * 2^11
  localparam logic [14:0] CodeHalf    = 15'd32767;        // floor(65535/2)
  localparam logic [16:0] CodeDenom   = 17'd65535;
  localparam logic [19:0] TempRecip   = 20'd838861;       // ceil(2^22 / 5)
  localparam int unsigned TempShift   = 22;

  // Stream widths
  localparam int unsigned OutDataW = 104;
  localparam int unsigned OutUserW = 2;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusBadLength = 2'd1,
    StatusBadType   = 2'd2,
    StatusOverflow  = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [7:0]         line_length;
    logic [7:0]         host_id;
    logic [7:0]         drive_id;
    logic [4:0]         fault_flags;
    logic [1:0]         run_state;
    logic signed [16:0] angle;
    logic signed [15:0] velocity;
    logic signed [15:0] torque;
    logic [16:0]        temperature;
  } result_t;

endpackage

FILE: design/motor_feedback_frame_parser_top.sv
// Motor feedback frame parser. One received byte is taken per cycle on the slave stream
// while s_axis_tready_o is high, and lines end on CR LF or after MaxLineBytes bytes; each
// finished line gives one transaction on the master stream, loaded into the output register
// or, while that is held, into a one-entry skid register. s_axis_tready_o is registered
// and drops only while the skid entry is full.
// Angle, velocity, torque and temperature are converted by short pipelines (one to three
// register stages) that run continuously off the captured code registers; in a 17-byte
// frame the terminator is accepted two, four, six and eight bytes after the last
// temperature, torque, velocity and angle byte, more than the one, two, two and three
// stages of those paths. No clearing pass follows reset.
module motor_feedback_frame_parser_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave stream: tdata = rx_byte[7:0]
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,
  // master stream: tdata = line_length[7:0], host_id[15:8], drive_id[23:16],
  //   fault_flags[28:24], run_state[30:29], angle[47:31], velocity[63:48],
  //   torque[79:64], temperature[96:80], zero pad[103:97]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [mffp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // master stream: tuser = frame_status[1:0]
  output logic [mffp_pkg::OutUserW-1:0]  m_axis_tuser_o
);

  localparam int unsigned CountW = mffp_pkg::CountW;

  // fold x/65535 for x below 2^32 - 1: quotient = hi + correction
  function automatic logic [16:0] fold_div(input logic [31:0] x);
    logic [16:0] sum;
    logic        corr;
    sum  = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    corr = (sum >= mffp_pkg::CodeDenom);
    return {1'b0, x[31:16]} + {16'd0, corr};
  endfunction

  // magnitude of 2*code - 65535 (negative when code[15] is clear)
  function automatic logic [15:0] code_mag(input logic [15:0] c);
    return {(c[15] ? c[14:0] : ~c[14:0]), 1'b1};
  endfunction

  // line state
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        prev_q, prev_d;
  logic [31:0]       header_q, header_d;
  logic [15:0]       angle_code_q, angle_code_d;
  logic [15:0]       vel_code_q, vel_code_d;
  logic [15:0]       torque_code_q, torque_code_d;
  logic [15:0]       temp_code_q, temp_code_d;

  // output register and skid entry
  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  mffp_pkg::result_t  out_q, out_d;
  mffp_pkg::result_t  skid_q, skid_d;

  logic              in_acc;
  logic              out_pop;
  logic [7:0]        rx_byte;
  logic [CountW-1:0] len;
  logic              term;
  logic              done;
  logic [31:0]       status_word;
  mffp_pkg::result_t res;

  assign rx_byte = s_axis_tdata_i;
  assign s_axis_tready_o = ~skid_valid_q;
  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_pop = out_valid_q & m_axis_tready_i;

  // terminator detect and line end
  assign len  = count_q + CountW'(1);
  assign term = (count_q != '0) && (prev_q == mffp_pkg::CharCr) &&
                (rx_byte == mffp_pkg::CharLf);
  assign done = term || (len >= CountW'(mffp_pkg::MaxLineBytes));

  // position-indexed capture
  always_comb begin
    count_d       = count_q;
    prev_d        = prev_q;
    header_d      = header_q;
    angle_code_d  = angle_code_q;
    vel_code_d    = vel_code_q;
    torque_code_d = torque_code_q;
    temp_code_d   = temp_code_q;
    if (in_acc) begin
      if (done) begin
        count_d       = '0;
        prev_d        = '0;
        header_d      = '0;
        angle_code_d  = '0;
        vel_code_d    = '0;
        torque_code_d = '0;
        temp_code_d   = '0;
      end else begin
        count_d = len;
        prev_d  = rx_byte;
        if (count_q >= mffp_pkg::PosHdrFirst && count_q <= mffp_pkg::PosHdrLast) begin
          header_d = {header_q[23:0], rx_byte};
        end
        if (count_q == mffp_pkg::PosAngleHi || count_q == mffp_pkg::PosAngleLo) begin
          angle_code_d = {angle_code_q[7:0], rx_byte};
        end
        if (count_q == mffp_pkg::PosVelHi || count_q == mffp_pkg::PosVelLo) begin
          vel_code_d = {vel_code_q[7:0], rx_byte};
        end
        if (count_q == mffp_pkg::PosTorqueHi || count_q == mffp_pkg::PosTorqueLo) begin
          torque_code_d = {torque_code_q[7:0], rx_byte};
        end
        if (count_q == mffp_pkg::PosTempHi || count_q == mffp_pkg::PosTempLo) begin
          temp_code_d = {temp_code_q[7:0], rx_byte};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      prev_q        <= '0;
      header_q      <= '0;
      angle_code_q  <= '0;
      vel_code_q    <= '0;
      torque_code_q <= '0;
      temp_code_q   <= '0;
    end else begin
      count_q       <= count_d;
      prev_q        <= prev_d;
      header_q      <= header_d;
      angle_code_q  <= angle_code_d;
      vel_code_q    <= vel_code_d;
      torque_code_q <= torque_code_d;
      temp_code_q   <= temp_code_d;
    end
  end

  // angle: three stages (split multiply, bias add, fold and sign)
  logic [33:0] ang_ph_q, ang_pl_q;
  logic        ang_neg1_q, ang_neg2_q;
  logic [51:0] ang_sum_q;
  logic [16:0] ang_q_val;
  logic [16:0] ang_res_q;
  logic [15:0] ang_mag;

  assign ang_mag   = code_mag(angle_code_q);
  assign ang_q_val = fold_div(ang_sum_q[51:20]);

  always_ff @(posedge clk_i) begin
    ang_ph_q   <= 34'(ang_mag) * 34'(mffp_pkg::AngleScale[35:18]);
    ang_pl_q   <= 34'(ang_mag) * 34'(mffp_pkg::AngleScale[17:0]);
    ang_neg1_q <= ~angle_code_q[15];
    ang_sum_q  <= {ang_ph_q[33:0], 18'd0} + 52'(ang_pl_q) + mffp_pkg::AngleBias;
    ang_neg2_q <= ang_neg1_q;
    ang_res_q  <= ang_neg2_q ? (17'd0 - ang_q_val) : ang_q_val;
  end

  // velocity and torque: multiply plus half, then fold and sign
  logic [30:0] vel_x_q, torque_x_q;
  logic        vel_neg_q, torque_neg_q;
  logic [15:0] vel_q_val, torque_q_val;
  logic [15:0] vel_res_q, torque_res_q;

  assign vel_q_val    = 16'(fold_div({1'b0, vel_x_q}));
  assign torque_q_val = 16'(fold_div({1'b0, torque_x_q}));

  always_ff @(posedge clk_i) begin
    vel_x_q      <= 31'(code_mag(vel_code_q)) * 31'(mffp_pkg::VelScale) +
                    31'(mffp_pkg::CodeHalf);
    vel_neg_q    <= ~vel_code_q[15];
    vel_res_q    <= vel_neg_q ? (16'd0 - vel_q_val) : vel_q_val;
    torque_x_q   <= 31'(code_mag(torque_code_q)) * 31'(mffp_pkg::TorqueScale) +
                    31'(mffp_pkg::CodeHalf);
    torque_neg_q <= ~torque_code_q[15];
    torque_res_q <= torque_neg_q ? (16'd0 - torque_q_val) : torque_q_val;
  end

  // temperature: floor((8*code + 2) / 5) by reciprocal multiply
  logic [38:0] temp_prod_q;

  always_ff @(posedge clk_i) begin
    temp_prod_q <= 39'({temp_code_q, 3'b000} + 19'd2) * 39'(mffp_pkg::TempRecip);
  end

  // result assembly
  assign status_word = header_q >> 3;

  always_comb begin
    res             = '0;
    res.line_length = 8'(len);
    if (!term) begin
      res.status = mffp_pkg::StatusOverflow;
    end else if (len != mffp_pkg::FrameLen) begin
      res.status = mffp_pkg::StatusBadLength;
    end else if (status_word[31:24] != mffp_pkg::FrameTypeFeedback) begin
      res.status = mffp_pkg::StatusBadType;
    end else begin
      res.status      = mffp_pkg::StatusOk;
      res.host_id     = status_word[7:0];
      res.drive_id    = status_word[15:8];
      res.fault_flags = status_word[20:16];
      res.run_state   = status_word[23:22];
      res.angle       = ang_res_q;
      res.velocity    = vel_res_q;
      res.torque      = torque_res_q;
      res.temperature = temp_prod_q[mffp_pkg::TempShift +: 17];
    end
  end

  // output register with skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_acc && done) begin
      if (!out_valid_q || out_pop) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // stream packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {7'd0, out_q.temperature, out_q.torque, out_q.velocity,
                            out_q.angle, out_q.run_state, out_q.fault_flags,
                            out_q.drive_id, out_q.host_id, out_q.line_length};

endmodule

FILE: design/mffp_checker.sv
`include "motor_feedback_frame_parser_top_assert.svh"

// Port-level checks on the result stream of the frame parser.
module mffp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [mffp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [mffp_pkg::OutUserW-1:0]  m_axis_tuser_o
);

  localparam logic [7:0] OverflowLen = 8'(mffp_pkg::MaxLineBytes);
  localparam logic [7:0] GoodLen     = 8'(mffp_pkg::FrameLen);

  logic stall;
  logic is_ok;
  logic is_bad_len;
  logic is_overflow;

  assign stall       = m_axis_tvalid_o && !m_axis_tready_i;
  assign is_ok       = m_axis_tvalid_o && (m_axis_tuser_o == mffp_pkg::StatusOk);
  assign is_bad_len  = m_axis_tvalid_o && (m_axis_tuser_o == mffp_pkg::StatusBadLength);
  assign is_overflow = m_axis_tvalid_o && (m_axis_tuser_o == mffp_pkg::StatusOverflow);

  // a stalled result holds
  `MFFP_ASSERT_NEXT(a_stall_hold, stall, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  // a good frame is always 17 bytes
  `MFFP_ASSERT_SAME(a_ok_len, is_ok, m_axis_tdata_o[7:0] == GoodLen, "ok frame with wrong length")

  // a length error never reports the frame length
  `MFFP_ASSERT_SAME(a_bad_len, is_bad_len, m_axis_tdata_o[7:0] != GoodLen, "length error on 17 bytes")

  // overflow reports the full line count
  `MFFP_ASSERT_SAME(a_ovf_len, is_overflow, m_axis_tdata_o[7:0] == OverflowLen, "overflow length mismatch")

  // decoded fields are zero on any error
  `MFFP_ASSERT_SAME(a_err_zero, m_axis_tvalid_o && !is_ok, m_axis_tdata_o[103:8] == '0, "error result carries data")

endmodule

bind motor_feedback_frame_parser_top mffp_checker u_mffp_checker (.*);

FILE: test/testbench.sv
module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // stream signals; the bench drives s_tvalid, s_tdata and m_tready
  logic                          s_tvalid = 1'b0;
  logic [7:0]                    s_tdata  = '0;
  logic                          m_tready = 1'b0;
  logic                          s_tready;
  logic                          m_tvalid;
  logic [mffp_pkg::OutDataW-1:0] m_tdata;
  logic [mffp_pkg::OutUserW-1:0] m_tuser;

  // idling knobs, in percent
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // line parser shadow state
  int unsigned line_pos  = 0;
  logic [7:0]  last_byte = '0;
  logic [31:0] hdr_acc   = '0;
  logic [15:0] ang_acc   = '0;
  logic [15:0] vel_acc   = '0;
  logic [15:0] trq_acc   = '0;
  logic [15:0] tmp_acc   = '0;

  mffp_pkg::result_t pending_results[$];
  int unsigned sent_bytes  = 0;
  int unsigned error_count = 0;

  localparam longint unsigned CodeSpan   = 64'd65535;
  localparam longint unsigned AngleQ20   = 64'd53972150818;
  localparam longint unsigned VelFactor  = 64'd30720;
  localparam longint unsigned TrqFactor  = 64'd24576;

  motor_feedback_frame_parser_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // round((2c - 65535) * k / d), ties away from zero
  function automatic longint unsigned scale_code(input logic [15:0] code,
                                                  input longint unsigned k,
                                                  input longint unsigned d);
    longint          twice;
    longint unsigned mag;
    longint unsigned q;
    twice = 2 * longint'(code) - 65535;
    mag = (twice < 0) ? longint'(-twice) : twice;
    q = (2 * mag * k + d) / (2 * d);
    return (twice < 0) ? (64'd0 - q) : q;
  endfunction

  // advance the shadow parser by one byte; returns 1 when a line completes
  function automatic bit parse_byte(input logic [7:0] b, output mffp_pkg::result_t r);
    int unsigned len;
    bit          term;
    logic [28:0] st;
    r = '0;
    case (line_pos)
      2, 3, 4, 5: hdr_acc = {hdr_acc[23:0], b};
      7, 8:       ang_acc = {ang_acc[7:0], b};
      9, 10:      vel_acc = {vel_acc[7:0], b};
      11, 12:     trq_acc = {trq_acc[7:0], b};
      13, 14:     tmp_acc = {tmp_acc[7:0], b};
      default: ;
    endcase
    len = line_pos + 1;
    term = (len >= 2) && (last_byte == mffp_pkg::CharCr) && (b == mffp_pkg::CharLf);
    if (!term && len < mffp_pkg::MaxLineBytes) begin
      line_pos = len;
      last_byte = b;
      return 1'b0;
    end
    r.line_length = len[7:0];
    if (!term) begin
      r.status = mffp_pkg::StatusOverflow;
    end else if (len != 17) begin
      r.status = mffp_pkg::StatusBadLength;
    end else begin
      st = hdr_acc[31:3];
      if (8'(st[28:24]) != mffp_pkg::FrameTypeFeedback) begin
        r.status = mffp_pkg::StatusBadType;
      end else begin
        r.status      = mffp_pkg::StatusOk;
        r.host_id     = st[7:0];
        r.drive_id    = st[15:8];
        r.fault_flags = st[20:16];
        r.run_state   = st[23:22];
        r.angle       = 17'(scale_code(ang_acc, AngleQ20, CodeSpan << 20));
        r.velocity    = 16'(scale_code(vel_acc, VelFactor, CodeSpan));
        r.torque      = 16'(scale_code(trq_acc, TrqFactor, CodeSpan));
        r.temperature = 17'((longint'(tmp_acc) * 32 + 10) / 20);
      end
    end
    line_pos  = 0;
    last_byte = '0;
    hdr_acc   = '0;
    ang_acc   = '0;
    vel_acc   = '0;
    trq_acc   = '0;
    tmp_acc   = '0;
    return 1'b1;
  endfunction

  // send one byte; valid stays high afterwards so bytes can go back to back
  task automatic send_byte(input logic [7:0] b);
    mffp_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (parse_byte(b, r)) pending_results.push_back(r);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [31:0] hdr, input logic [7:0] b6,
                            input logic [15:0] ang, input logic [15:0] vel,
                            input logic [15:0] trq, input logic [15:0] tmp);
    logic [7:0] bytes [17];
    bytes = '{b0, b1, hdr[31:24], hdr[23:16], hdr[15:8], hdr[7:0], b6,
              ang[15:8], ang[7:0], vel[15:8], vel[7:0], trq[15:8], trq[7:0],
              tmp[15:8], tmp[7:0], mffp_pkg::CharCr, mffp_pkg::CharLf};
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic send_fill(input int unsigned n, input logic [7:0] b);
    repeat (n) send_byte(b);
  endtask

  function automatic logic [15:0] pick_code();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // receiver backpressure
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  initial begin
    mffp_pkg::result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: tdata %0h tuser %0h", m_tdata, m_tuser);
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("frame_status", exp_r.status,      m_tuser);
          check_field("line_length",  exp_r.line_length, m_tdata[7:0]);
          check_field("host_id",      exp_r.host_id,     m_tdata[15:8]);
          check_field("drive_id",     exp_r.drive_id,    m_tdata[23:16]);
          check_field("fault_flags",  exp_r.fault_flags, m_tdata[28:24]);
          check_field("run_state",    exp_r.run_state,   m_tdata[30:29]);
          check_field("angle",        unsigned'(exp_r.angle),    m_tdata[47:31]);
          check_field("velocity",     unsigned'(exp_r.velocity), m_tdata[63:48]);
          check_field("torque",       unsigned'(exp_r.torque),   m_tdata[79:64]);
          check_field("temperature",  exp_r.temperature, m_tdata[96:80]);
        end
      end
    end
  end

  // well-formed frames at the code and header extremes
  task automatic test_frame_extremes();
    send_frame(8'h00, 8'h00, {5'd2, 27'd0}, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_frame(8'hFF, 8'hFF, {5'd2, 27'h7FFFFFF}, 8'hFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(8'h5A, 8'hA5, {5'd2, 27'h2AAAAAA}, 8'h3C,
               16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
  endtask

  // frame type other than feedback
  task automatic test_bad_type();
    send_frame(8'h01, 8'h02, {5'd3, 27'h1234567}, 8'h00,
               16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    send_frame(8'h01, 8'h02, {5'd0, 27'h7654321}, 8'h00,
               16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
  endtask

  // short lines, lone LF at line start, bytes counted past the capture window
  task automatic test_short_lines();
    send_byte(mffp_pkg::CharLf);
    send_byte(mffp_pkg::CharCr);
    send_byte(mffp_pkg::CharLf);
    send_byte(mffp_pkg::CharCr);
    send_byte(mffp_pkg::CharLf);
    send_fill(18, 8'h33);
    send_byte(mffp_pkg::CharCr);
    send_byte(mffp_pkg::CharLf);
  endtask

  // terminator on the last allowed byte, then overflow, then lone LF after it
  task automatic test_line_limits();
    send_fill(mffp_pkg::MaxLineBytes - 2, 8'h55);
    send_byte(mffp_pkg::CharCr);
    send_byte(mffp_pkg::CharLf);
    send_fill(mffp_pkg::MaxLineBytes - 1, 8'h41);
    send_byte(mffp_pkg::CharCr);
    send_byte(mffp_pkg::CharLf);
    send_byte(mffp_pkg::CharCr);
    send_byte(mffp_pkg::CharLf);
  endtask

  // mostly well-formed frames with random content, plus broken lines and noise
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned sel;
    int unsigned len;
    stop_at = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        send_frame(8'($urandom()), 8'($urandom()), {5'd2, 27'($urandom())},
                   8'($urandom()), pick_code(), pick_code(), pick_code(), pick_code());
      end else if (sel < 78) begin
        send_frame(8'($urandom()), 8'($urandom()), $urandom(), 8'($urandom()),
                   pick_code(), pick_code(), pick_code(), pick_code());
      end else if (sel < 90) begin
        // line of random length ending in CR LF
        len = $urandom_range(1, 30);
        repeat (len) send_byte(8'($urandom()));
        send_byte(mffp_pkg::CharCr);
        send_byte(mffp_pkg::CharLf);
      end else if (sel < 98) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom()));
      end else begin
        // long run that may overflow
        repeat ($urandom_range(240, 270)) send_byte(8'($urandom_range(16, 255)));
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(0, 0);
    test_frame_extremes();
    test_bad_type();
    test_short_lines();
    test_line_limits();

    set_idling(0, 0);
    test_random_traffic(155);
    set_idling(69, 0);
    test_random_traffic(155);
    set_idling(0, 69);
    test_random_traffic(155);
    set_idling(26, 26);
    test_random_traffic(155);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
